@@ design/saob_pkg.sv @@
// ----------------------------------------------------------------------------
// saob_pkg: shared types and constants for the straight-alpha over blend
// widths of the divider datapath, rounding constants and pipeline depths
// ----------------------------------------------------------------------------
package saob_pkg;

  localparam int ChanCount  = 3;
  localparam int NumW       = 25;
  localparam int DenW       = 16;
  localparam int RemW       = 24;
  localparam int DivSteps   = 8;
  localparam int DivLat     = DivSteps + 1;
  localparam int FrontLat   = 5;
  localparam int Stages     = FrontLat + DivLat + 1;
  localparam int RecipShift = 23;

  localparam logic [7:0]  Full  = 8'd255;
  localparam logic [7:0]  Round = 8'd127;
  localparam logic [15:0] Recip = 16'd32897;

  typedef logic [ChanCount-1:0][7:0] col_t;

  typedef struct packed {
    logic [7:0] alpha;
    col_t       col;
  } pix_t;

  typedef struct packed {
    pix_t       dst;
    logic [7:0] oa;
    logic       pass;
    logic       zero;
  } side_t;

  // rounded v / 255 through a reciprocal, exact for v up to 255 * 255
  function automatic logic [7:0] div255_round(input logic [15:0] v);
    logic [16:0] x;
    logic [32:0] prod;
    x    = 17'(v) + 17'(Round);
    prod = 33'(x) * 33'(Recip);
    return prod[RecipShift+7:RecipShift];
  endfunction

endpackage

@@ design/saob_in_if.sv @@
// ----------------------------------------------------------------------------
// saob_in_if: input pixel channel
// source colour, coverage, opacity and destination pixel with valid/ready
// ----------------------------------------------------------------------------
interface saob_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] coverage;
  logic [7:0] opacity;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] dst_red;
  logic [7:0] dst_green;
  logic [7:0] dst_blue;
  logic [7:0] dst_alpha;

  modport source (
    output valid, coverage, opacity, src_red, src_green, src_blue,
    output dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, coverage, opacity, src_red, src_green, src_blue,
    input  dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

@@ design/saob_out_if.sv @@
// ----------------------------------------------------------------------------
// saob_out_if: output pixel channel
// blended rgba pixel with valid/ready
// ----------------------------------------------------------------------------
interface saob_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

@@ design/saob_div.sv @@
// ----------------------------------------------------------------------------
// saob_div: pipelined restoring divider, one quotient bit per stage
// saturating 8-bit quotient; one overflow check stage then eight steps
// ----------------------------------------------------------------------------
module saob_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [saob_pkg::NumW-1:0]  num_i,
  input  logic [saob_pkg::DenW-1:0]  den_i,
  output logic [7:0]                 quo_o
);

  localparam int Steps = saob_pkg::DivSteps;
  localparam int RemW  = saob_pkg::RemW;
  localparam int DenW  = saob_pkg::DenW;

  logic            sat_q [Steps+1];
  logic [RemW-1:0] rem_q [Steps+1];
  logic [DenW-1:0] den_q [Steps+1];
  logic [7:0]      quo_q [Steps+1];

  // quotient of 256 or more saturates
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0] <= num_i >= {1'b0, den_i, 8'h00};
      rem_q[0] <= num_i[RemW-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= Steps; k++) begin : g_step
    localparam int Bit = Steps - k;
    logic [RemW-1:0] sub;
    logic            ge;
    logic [7:0]      quo_nx;

    always_comb begin
      sub         = RemW'(den_q[k-1]) << Bit;
      ge          = rem_q[k-1] >= sub;
      quo_nx      = quo_q[k-1];
      quo_nx[Bit] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sat_q[k] <= sat_q[k-1];
        den_q[k] <= den_q[k-1];
        rem_q[k] <= ge ? rem_q[k-1] - sub : rem_q[k-1];
        quo_q[k] <= quo_nx;
      end
    end
  end

  assign quo_o = sat_q[Steps] ? 8'hFF : quo_q[Steps];

endmodule

@@ design/straight_alpha_over_blend.sv @@
// ----------------------------------------------------------------------------
// straight_alpha_over_blend: 8-bit straight-alpha over compositing
// source colour with coverage and opacity blended onto an rgba pixel
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   transfer
//  in_i     in   coverage, opacity, src rgb, dst rgba      valid & ready
//  out_o    out  out_red, out_green, out_blue, out_alpha   valid & ready
//
//  one pixel per clock while the output is not stalled
//  the per-channel divider computes one quotient bit per stage
//  reset clears only the stage valid bits
//  a stalled output freezes the whole pipeline; input ready follows it
// ----------------------------------------------------------------------------
module straight_alpha_over_blend (
  input  logic              clk_i,
  input  logic              rst_ni,
  saob_in_if.sink           in_i,
  saob_out_if.source        out_o
);

  localparam int Chans  = saob_pkg::ChanCount;
  localparam int Stages = saob_pkg::Stages;
  localparam int DivLat = saob_pkg::DivLat;

  logic              en;
  logic [Stages-1:0] vld_q;

  // stage 1
  logic [15:0]       p1_q;
  saob_pkg::col_t    src1_q;
  saob_pkg::pix_t    dst1_q;
  // stage 2
  logic [7:0]        a2_q;
  saob_pkg::col_t    src2_q;
  saob_pkg::pix_t    dst2_q;
  // stage 3
  logic [7:0]        a3_q;
  logic [7:0]        inv3_q;
  logic [15:0]       t3_q;
  logic [Chans-1:0][15:0] sa3_q;
  logic [Chans-1:0][15:0] dd3_q;
  logic              pass3_q;
  saob_pkg::pix_t    dst3_q;
  // stage 4
  logic [Chans-1:0][23:0] sa4_q;
  logic [Chans-1:0][23:0] dd4_q;
  saob_pkg::side_t   side4_q;
  // stage 5
  logic [Chans-1:0][saob_pkg::NumW-1:0] num5_q;
  logic [saob_pkg::DenW-1:0]            den5_q;
  saob_pkg::side_t   side5_q;
  // divider alignment
  saob_pkg::side_t   side_q [DivLat];
  logic [Chans-1:0][7:0] quo;
  // output
  saob_pkg::pix_t    out_q;

  logic [7:0]        inv3_d;
  logic [7:0]        oa4_d;
  saob_pkg::side_t   last;

  assign en         = out_o.ready || !vld_q[Stages-1];
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], in_i.valid};
    end
  end

  assign inv3_d = saob_pkg::Full - a2_q;
  assign oa4_d  = a3_q + saob_pkg::div255_round(t3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // source alpha product
      p1_q           <= 16'(in_i.coverage) * 16'(in_i.opacity);
      src1_q         <= {in_i.src_blue, in_i.src_green, in_i.src_red};
      dst1_q.col     <= {in_i.dst_blue, in_i.dst_green, in_i.dst_red};
      dst1_q.alpha   <= in_i.dst_alpha;

      a2_q           <= saob_pkg::div255_round(p1_q);
      src2_q         <= src1_q;
      dst2_q         <= dst1_q;

      a3_q           <= a2_q;
      inv3_q         <= inv3_d;
      t3_q           <= 16'(dst2_q.alpha) * 16'(inv3_d);
      pass3_q        <= a2_q == 8'd0;
      dst3_q         <= dst2_q;
      for (int c = 0; c < Chans; c++) begin
        sa3_q[c] <= 16'(src2_q[c]) * 16'(a2_q);
        dd3_q[c] <= 16'(dst2_q.col[c]) * 16'(dst2_q.alpha);
      end

      for (int c = 0; c < Chans; c++) begin
        sa4_q[c] <= (24'(sa3_q[c]) << 8) - 24'(sa3_q[c]);
        dd4_q[c] <= 24'(dd3_q[c]) * 24'(inv3_q);
      end
      side4_q.dst  <= dst3_q;
      side4_q.oa   <= oa4_d;
      side4_q.pass <= pass3_q;
      side4_q.zero <= oa4_d == 8'd0;

      // dividend with rounding term, divisor oa * 255
      for (int c = 0; c < Chans; c++) begin
        num5_q[c] <= 25'(sa4_q[c]) + 25'(dd4_q[c])
                   + (25'(side4_q.oa) << 7) - 25'(side4_q.oa);
      end
      den5_q  <= (16'(side4_q.oa) << 8) - 16'(side4_q.oa);
      side5_q <= side4_q;

      side_q[0] <= side5_q;
      for (int s = 1; s < DivLat; s++) begin
        side_q[s] <= side_q[s-1];
      end

      if (last.pass) begin
        out_q <= last.dst;
      end else if (last.zero) begin
        out_q <= '0;
      end else begin
        out_q.col   <= quo;
        out_q.alpha <= last.oa;
      end
    end
  end

  assign last = side_q[DivLat-1];

  for (genvar c = 0; c < Chans; c++) begin : g_div
    saob_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num5_q[c]),
      .den_i (den5_q),
      .quo_o (quo[c])
    );
  end

  assign out_o.valid     = vld_q[Stages-1];
  assign out_o.out_red   = out_q.col[0];
  assign out_o.out_green = out_q.col[1];
  assign out_o.out_blue  = out_q.col[2];
  assign out_o.out_alpha = out_q.alpha;

`ifndef ASSERT_OFF
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> vld_q == $past(vld_q))
    else $error("pipeline moved during output stall");

  a_zero_only_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && side4_q.zero |-> side4_q.pass)
    else $error("zero output alpha with nonzero source alpha");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] && !side5_q.pass |-> den5_q != '0)
    else $error("zero divisor reached the divider");
`endif

endmodule

@@ dv/straight_alpha_over_blend_tb.sv @@
// ----------------------------------------------------------------------------
// straight_alpha_over_blend_tb: self-checking bench for the over blend
// A table of directed pixels is run first, then random pixels in three idle
// mixes. The input and output channels stall at random, and the output also
// holds off for a long stretch. Every output transfer is checked field by
// field against a predicted queue of blended pixels.
// ----------------------------------------------------------------------------
module straight_alpha_over_blend_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PipeDepth    = 15;
  localparam int RandPerPhase = 210;
  localparam int HoldLen      = 80;
  localparam int MaxReports   = 10;
  localparam int NumDirected  = 20;

  typedef struct packed {
    logic [7:0] coverage;
    logic [7:0] opacity;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_res_t;

  typedef struct packed {
    pixel_req_t req;
    logic       typed;
    pixel_res_t res;
  } blend_case_t;

  // typed rows: pass-through, fully opaque source, all-white
  localparam blend_case_t DirectedCases [NumDirected] = '{
    '{'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
      1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd12,  8'd34,  8'd56,  8'd78},
      1'b1, '{8'd12, 8'd34, 8'd56, 8'd78}},
    '{'{8'd255, 8'd0,   8'd200, 8'd201, 8'd202, 8'd1,   8'd2,   8'd3,   8'd4},
      1'b1, '{8'd1, 8'd2, 8'd3, 8'd4}},
    '{'{8'd255, 8'd255, 8'd10,  8'd20,  8'd30,  8'd99,  8'd88,  8'd77,  8'd66},
      1'b1, '{8'd10, 8'd20, 8'd30, 8'd255}},
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
      1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
    '{'{8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255},
      1'b1, '{8'd0, 8'd0, 8'd0, 8'd255}},
    '{'{8'd1,   8'd127, 8'd9,   8'd8,   8'd7,   8'd200, 8'd100, 8'd50,  8'd25},
      1'b1, '{8'd200, 8'd100, 8'd50, 8'd25}},
    '{'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255},
      1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
    '{'{8'd1,   8'd128, 8'd77,  8'd140, 8'd3,   8'd10,  8'd20,  8'd30,  8'd0},
      1'b0, '0},
    '{'{8'd128, 8'd255, 8'd255, 8'd128, 8'd0,   8'd0,   8'd64,  8'd255, 8'd0},
      1'b0, '0},
    '{'{8'd128, 8'd255, 8'd255, 8'd128, 8'd0,   8'd0,   8'd64,  8'd255, 8'd255},
      1'b0, '0},
    '{'{8'd255, 8'd128, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255},
      1'b0, '0},
    '{'{8'd64,  8'd64,  8'd250, 8'd5,   8'd128, 8'd17,  8'd200, 8'd90,  8'd180},
      1'b0, '0},
    '{'{8'd255, 8'd1,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd100},
      1'b0, '0},
    '{'{8'd128, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255},
      1'b0, '0},
    '{'{8'd170, 8'd85,  8'd170, 8'd170, 8'd170, 8'd85,  8'd85,  8'd85,  8'd85},
      1'b0, '0},
    '{'{8'd85,  8'd170, 8'd85,  8'd85,  8'd85,  8'd170, 8'd170, 8'd170, 8'd170},
      1'b0, '0},
    '{'{8'd200, 8'd200, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd1},
      1'b0, '0},
    '{'{8'd2,   8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd254},
      1'b0, '0},
    '{'{8'd254, 8'd255, 8'd33,  8'd66,  8'd99,  8'd240, 8'd120, 8'd60,  8'd128},
      1'b0, '0}
  };

  logic clk;
  logic rst_n;

  saob_in_if  in_if ();
  saob_out_if out_if ();

  straight_alpha_over_blend dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pixel_res_t blended_q [$];
  pixel_res_t next_blend;
  pixel_res_t got_px;
  pixel_res_t want_px;
  int         send_idle_pct;
  int         sink_idle_pct;
  int         hold_left;
  int         hold_at;
  int         accepted_cnt;
  int         result_cnt;
  int         fault_cnt;
  int         passthru_cnt;

  always #5 clk = ~clk;

  function automatic logic [7:0] mix_channel(input logic [31:0] src, input logic [31:0] dst,
                                             input logic [31:0] a, input logic [31:0] da,
                                             input logic [31:0] inv, input logic [31:0] oa);
    logic [31:0] q;
    q = (src * a * 32'(saob_pkg::Full) + dst * da * inv + oa * 32'(saob_pkg::Round))
        / (oa * 32'(saob_pkg::Full));
    return (q > 32'(saob_pkg::Full)) ? saob_pkg::Full : q[7:0];
  endfunction

  function automatic pixel_res_t blend_over(input pixel_req_t p);
    logic [31:0] a;
    logic [31:0] inv;
    logic [31:0] oa;
    pixel_res_t  r;
    a = (32'(p.coverage) * 32'(p.opacity) + 32'(saob_pkg::Round)) / 32'(saob_pkg::Full);
    if (a == 0) begin
      r = '{p.dst_red, p.dst_green, p.dst_blue, p.dst_alpha};
      return r;
    end
    inv = 32'(saob_pkg::Full) - a;
    oa  = a + (32'(p.dst_alpha) * inv + 32'(saob_pkg::Round)) / 32'(saob_pkg::Full);
    if (oa == 0) begin
      return '0;
    end
    r.red   = mix_channel(32'(p.src_red), 32'(p.dst_red), a, 32'(p.dst_alpha), inv, oa);
    r.green = mix_channel(32'(p.src_green), 32'(p.dst_green), a, 32'(p.dst_alpha), inv, oa);
    r.blue  = mix_channel(32'(p.src_blue), 32'(p.dst_blue), a, 32'(p.dst_alpha), inv, oa);
    r.alpha = oa[7:0];
    return r;
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_req_t random_pixel();
    pixel_req_t p;
    p.coverage  = ($urandom_range(9) == 0) ? 8'($urandom_range(2)) : pick_level();
    p.opacity   = $urandom_range(1) ? saob_pkg::Full : pick_level();
    p.src_red   = pick_level();
    p.src_green = pick_level();
    p.src_blue  = pick_level();
    p.dst_red   = pick_level();
    p.dst_green = pick_level();
    p.dst_blue  = pick_level();
    p.dst_alpha = pick_level();
    return p;
  endfunction

  task automatic log_fault(input string what, input pixel_res_t want, input pixel_res_t got);
    fault_cnt++;
    if (fault_cnt <= MaxReports) begin
      $display("%0t %s: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
               $realtime, what, want.red, want.green, want.blue, want.alpha,
               got.red, got.green, got.blue, got.alpha);
    end
  endtask

  // starts and ends at a falling edge; valid stays up for a following transfer
  task automatic offer_pixel(input pixel_req_t req, input pixel_res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    next_blend = want;
    if (want == {req.dst_red, req.dst_green, req.dst_blue, req.dst_alpha}) begin
      passthru_cnt++;
    end
    in_if.valid <= 1'b1;
    {in_if.coverage, in_if.opacity, in_if.src_red, in_if.src_green, in_if.src_blue,
     in_if.dst_red, in_if.dst_green, in_if.dst_blue, in_if.dst_alpha} <= req;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (blended_q.size() != 0) @(negedge clk);
  endtask

  // predicted results queued on input transfer, checked on output transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        blended_q = {blended_q, next_blend};
        accepted_cnt++;
      end
      if (out_if.valid && out_if.ready) begin
        got_px = '{out_if.out_red, out_if.out_green, out_if.out_blue, out_if.out_alpha};
        result_cnt++;
        if (blended_q.size() == 0) begin
          log_fault("unexpected transfer", '0, got_px);
        end else begin
          want_px = blended_q.pop_front();
          if (got_px.red !== want_px.red || got_px.green !== want_px.green ||
              got_px.blue !== want_px.blue || got_px.alpha !== want_px.alpha) begin
            log_fault("pixel mismatch", want_px, got_px);
          end
        end
      end
    end
  end

  // output ready: random stalls plus one long hold-off counted here
  initial begin
    bit hold_done;
    hold_done    = 1'b0;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && accepted_cnt >= hold_at) begin
        hold_left = HoldLen;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int         k;
    int         ph;
    pixel_req_t req;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    {in_if.coverage, in_if.opacity, in_if.src_red, in_if.src_green, in_if.src_blue,
     in_if.dst_red, in_if.dst_green, in_if.dst_blue, in_if.dst_alpha} = '0;
    next_blend    = '0;
    send_idle_pct = 22;
    sink_idle_pct = 55;
    hold_at       = 32'h7fff_ffff;
    accepted_cnt  = 0;
    result_cnt    = 0;
    fault_cnt     = 0;
    passthru_cnt  = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (k = 0; k < NumDirected; k++) begin
      offer_pixel(DirectedCases[k].req, DirectedCases[k].typed ?
                  DirectedCases[k].res : blend_over(DirectedCases[k].req));
    end
    wait_drained();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 22;
          sink_idle_pct = 55;
        end
        1: begin
          send_idle_pct = 55;
          sink_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          sink_idle_pct = 0;
          hold_at       = accepted_cnt + 50;
        end
      endcase
      for (k = 0; k < RandPerPhase; k++) begin
        req = random_pixel();
        offer_pixel(req, blend_over(req));
      end
      wait_drained();
    end

    repeat (2 * PipeDepth) @(negedge clk);
    while (blended_q.size() != 0) begin
      log_fault("missing transfer", blended_q.pop_front(), '0);
    end

    $display("covered %0d pixels in (%0d directed), %0d results out, %0d pass-through",
             accepted_cnt, NumDirected, result_cnt, passthru_cnt);
    $display("three idle mixes plus a %0d-cycle output hold-off, %0d faults",
             HoldLen, fault_cnt);
    if (fault_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
